>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the background mask block.
// Each macro checks on the rising edge of clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CCBM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CCBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ccbm_pkg.sv
// Shared widths, operation codes and helper functions for the background mask block.
// Has no dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package ccbm_pkg;

  localparam int unsigned DIM_W = 9;   // image dimension registers
  localparam int unsigned THR_W = 12;  // distance threshold
  localparam int unsigned PIX_W = 8;   // one Lab channel
  localparam int unsigned BG_W  = 16;  // background channel, 8 fractional bits
  localparam int unsigned SR_W  = 5;   // sample square side, up to 16
  localparam int unsigned N_W   = 9;   // sample count, up to 256
  localparam int unsigned SUM_W = 16;  // channel sum over one sample square
  localparam int unsigned DVD_W = 24;  // rounded mean dividend
  localparam int unsigned ACC_W = 18;  // sum of four corner means
  localparam int unsigned SQ_W  = 34;  // squared Lab distance
  localparam int unsigned LIM_W = 32;  // squared threshold, aligned to SQ_W

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_PROCESS = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  localparam logic [1:0] REG_WIDTH     = 2'd0;
  localparam logic [1:0] REG_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  // 5x5 elliptical structuring element, bit k of a row is column k
  localparam logic [4:0] ELLIPSE [5] = '{5'h04, 5'h1F, 5'h1F, 5'h1F, 5'h04};

  // Channel 0 is L, 1 is a, 2 is b
  function automatic logic [PIX_W-1:0] chan_of(input logic [3*PIX_W-1:0] pix,
                                               input logic [1:0] ch);
    logic [PIX_W-1:0] v;
    case (ch)
      2'd0:    v = pix[3*PIX_W-1:2*PIX_W];
      2'd1:    v = pix[2*PIX_W-1:PIX_W];
      default: v = pix[PIX_W-1:0];
    endcase
    return v;
  endfunction

endpackage

>>> rtl/ccbm_divider.sv
// Restoring divider, one quotient bit per cycle, used for the rounded corner means.
// Depends on ccbm_pkg for DVD_W and N_W.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ccbm_divider
  import ccbm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [N_W-1:0]   divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] dvd_q;
  logic [N_W-1:0]   rem_q, dsr_q;
  logic [N_W:0]     trial;
  logic             ge;
  logic [N_W:0]     diff;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift the quotient bits into the dividend register as it empties
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], ge};
      rem_q <= ge ? diff[N_W-1:0] : trial[N_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

  `CCBM_ASSERT_IMPL(a_div_nonzero, busy_q, dsr_q != '0, "divider running with zero divisor")
  `CCBM_ASSERT_IMPL(a_div_no_restart, start_i, !busy_q, "divider started while busy")
  `CCBM_ASSERT_IMPL(a_div_done_idle, done_q, !busy_q && cnt_q == '0, "done while busy")

endmodule

>>> rtl/corner_color_background_mask.sv
// Background mask over a stored frame of 8-bit Lab pixels. A load beat writes one
// pixel in its cycle and gives no result; a read beat passes through the S_RD and
// S_RESP states and then registers its result, which can wait on out_stall_i. A
// process beat runs a sequencer over frame and mask memories with one read and one
// write port each: an address state and an accumulate state per corner sample pixel,
// twelve divisions on the one shared divider, a distance pass over each pixel on the
// one shared multiplier, and four morphology passes, which read the 25 positions of
// the 5x5 ellipse window one a cycle from the mask memory. Input stays stalled meanwhile.
// Depends on ccbm_pkg and ccbm_divider.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module corner_color_background_mask
  import ccbm_pkg::*;
#(
  parameter int unsigned MAX_WIDTH     = 256,
  parameter int unsigned MAX_HEIGHT    = 256,
  parameter int unsigned SAMPLE_RADIUS = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        operation_i,
  input  logic [7:0]        pixel_row_i,
  input  logic [7:0]        pixel_col_i,
  input  logic [PIX_W-1:0]  lab_l_i,
  input  logic [PIX_W-1:0]  lab_a_i,
  input  logic [PIX_W-1:0]  lab_b_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        mask_value_o,
  output logic              mask_valid_o,
  output logic [BG_W-1:0]   background_l_o,
  output logic [BG_W-1:0]   background_a_o,
  output logic [BG_W-1:0]   background_b_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned WCLAMP = (MAX_WIDTH > 256) ? 256 : MAX_WIDTH;
  localparam int unsigned HCLAMP = (MAX_HEIGHT > 256) ? 256 : MAX_HEIGHT;
  localparam logic [DIM_W-1:0] W_MAX  = DIM_W'(WCLAMP);
  localparam logic [DIM_W-1:0] H_MAX  = DIM_W'(HCLAMP);
  localparam logic [SR_W-1:0]  SR_MAX = SR_W'(SAMPLE_RADIUS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_RESP  = 4'd2;
  localparam logic [3:0] S_SETUP = 4'd3;
  localparam logic [3:0] S_CADDR = 4'd4;
  localparam logic [3:0] S_CACC  = 4'd5;
  localparam logic [3:0] S_DIVST = 4'd6;
  localparam logic [3:0] S_DIVWT = 4'd7;
  localparam logic [3:0] S_BGFIN = 4'd8;
  localparam logic [3:0] S_TADDR = 4'd9;
  localparam logic [3:0] S_TDATA = 4'd10;
  localparam logic [3:0] S_TMUL  = 4'd11;
  localparam logic [3:0] S_TADD  = 4'd12;
  localparam logic [3:0] S_TCMP  = 4'd13;
  localparam logic [3:0] S_MRD   = 4'd14;
  localparam logic [3:0] S_MFIN  = 4'd15;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [DIM_W-1:0] r,
                                                input logic [DIM_W-1:0] c);
    return ADDR_W'(r * MAX_WIDTH) + ADDR_W'(c);
  endfunction

  // Memories
  logic [3*PIX_W-1:0] frame_mem  [DEPTH];
  logic               mask_a_mem [DEPTH];
  logic               mask_b_mem [DEPTH];

  // Configuration and state
  logic [DIM_W-1:0] width_q, height_q;
  logic [THR_W-1:0] thr_q;
  logic             proc_q;
  logic [BG_W-1:0]  bg_q [3];
  logic [3:0]       state_q;

  // Sequencer registers
  logic [SR_W-1:0]  sr_q, cr_q, cc_q;
  logic [N_W-1:0]   n_q;
  logic [LIM_W-1:0] limit_q;
  logic [1:0]       corner_q, ch_q, pass_q;
  logic [SUM_W-1:0] sum_q [3];
  logic [ACC_W-1:0] bgacc_q [3];
  logic [DIM_W-1:0] r_q, c_q;
  logic [3*PIX_W-1:0] pix_q, frame_rd_q;
  logic [SQ_W-1:0]  prod_q, dacc_q;
  logic [2:0]       dr_q, dc_q;
  logic             pend_q, acc_q;
  logic             a_rd_q, b_rd_q;
  logic             rd_ok_q, hit_q;
  logic             out_valid_q, out_mask_q, out_flag_q;
  logic [BG_W-1:0]  out_bg_q [3];

  // Effective dimensions
  logic [DIM_W-1:0] eff_w, eff_h, min_dim;
  logic [6:0]       quarter;
  logic [SR_W-1:0]  sr_c;
  logic [N_W-1:0]   sr_ext;
  logic [2*THR_W-1:0] thr_sq;

  assign eff_w   = (width_q == '0) ? DIM_W'(1) : ((width_q > W_MAX) ? W_MAX : width_q);
  assign eff_h   = (height_q == '0) ? DIM_W'(1) : ((height_q > H_MAX) ? H_MAX : height_q);
  assign min_dim = (eff_h < eff_w) ? eff_h : eff_w;
  assign quarter = min_dim[DIM_W-1:2];
  assign sr_c    = (quarter < 7'(SR_MAX)) ? quarter[SR_W-1:0] : SR_MAX;
  assign sr_ext  = N_W'(sr_c);
  assign thr_sq  = (2*THR_W)'(thr_q) * (2*THR_W)'(thr_q);

  // Handshake
  logic accept;
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign pready     = 1'b1;

  logic cfg_we;
  assign cfg_we = psel && penable && pwrite && pready;

  // Corner sampling addresses
  logic [DIM_W-1:0] r0, c0, cs_r, cs_c;
  assign r0   = corner_q[1] ? (eff_h - DIM_W'(sr_q)) : '0;
  assign c0   = corner_q[0] ? (eff_w - DIM_W'(sr_q)) : '0;
  assign cs_r = r0 + DIM_W'(cr_q);
  assign cs_c = c0 + DIM_W'(cc_q);

  // Distance datapath
  logic [PIX_W-1:0]  ch_val;
  logic signed [17:0] diff;
  logic [16:0]       absd;
  logic [SQ_W-1:0]   prod_c;
  assign ch_val = chan_of(pix_q, ch_q);
  assign diff   = $signed({2'b0, ch_val, 8'b0}) - $signed({2'b0, bg_q[ch_q]});
  assign absd   = diff[17] ? 17'(-diff) : diff[16:0];
  assign prod_c = SQ_W'(absd) * SQ_W'(absd);

  // Morphology neighbor
  logic [DIM_W:0]   rr_sum, cc_sum, rr_off, cc_off;
  logic             nb_ok, issue, dilate, src_is_a, src_rd, acc_next;
  logic [ADDR_W-1:0] nb_addr, pix_addr, host_addr;
  assign rr_sum   = {1'b0, r_q} + (DIM_W+1)'(dr_q);
  assign cc_sum   = {1'b0, c_q} + (DIM_W+1)'(dc_q);
  assign rr_off   = rr_sum - (DIM_W+1)'(2);
  assign cc_off   = cc_sum - (DIM_W+1)'(2);
  assign nb_ok    = (rr_sum >= (DIM_W+1)'(2)) && (rr_off < {1'b0, eff_h}) &&
                    (cc_sum >= (DIM_W+1)'(2)) && (cc_off < {1'b0, eff_w});
  assign issue    = nb_ok && ELLIPSE[dr_q][dc_q];
  assign nb_addr  = addr_of(rr_off[DIM_W-1:0], cc_off[DIM_W-1:0]);
  assign pix_addr = addr_of(r_q, c_q);
  assign host_addr = addr_of(DIM_W'(pixel_row_i), DIM_W'(pixel_col_i));
  assign dilate   = (pass_q == 2'd0) || (pass_q == 2'd3);
  assign src_is_a = !pass_q[0];
  assign src_rd   = src_is_a ? a_rd_q : b_rd_q;
  assign acc_next = pend_q ? (dilate ? (acc_q | src_rd) : (acc_q & src_rd)) : acc_q;

  logic last_col, last_row;
  assign last_col = (c_q == eff_w - DIM_W'(1));
  assign last_row = (r_q == eff_h - DIM_W'(1));

  // Divider
  logic             div_start, div_done;
  logic [DVD_W-1:0] div_q;
  assign div_start = (state_q == S_DIVST);

  ccbm_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({sum_q[ch_q], 8'b0} + DVD_W'(n_q[N_W-1:1])),
    .divisor_i  (n_q),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // Memory ports
  logic              frame_we, a_we, b_we, a_wd;
  logic [ADDR_W-1:0] frame_raddr, a_raddr;
  assign frame_we    = accept && (operation_i == OP_LOAD) &&
                       (32'(pixel_row_i) < 32'(MAX_HEIGHT)) &&
                       (32'(pixel_col_i) < 32'(MAX_WIDTH));
  assign frame_raddr = (state_q == S_CADDR) ? addr_of(cs_r, cs_c) : pix_addr;
  assign a_raddr     = (state_q == S_MRD && src_is_a) ? nb_addr : host_addr;
  assign a_we        = (state_q == S_TCMP) || (state_q == S_MFIN && !src_is_a);
  assign b_we        = (state_q == S_MFIN) && src_is_a;
  assign a_wd        = (state_q == S_TCMP) ? (dacc_q > SQ_W'(limit_q)) : acc_next;

  always_ff @(posedge clk_i) begin
    if (frame_we) begin
      frame_mem[host_addr] <= {lab_l_i, lab_a_i, lab_b_i};
    end
    frame_rd_q <= frame_mem[frame_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      mask_a_mem[pix_addr] <= a_wd;
    end
    a_rd_q <= mask_a_mem[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      mask_b_mem[pix_addr] <= acc_next;
    end
    b_rd_q <= mask_b_mem[nb_addr];
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(256);
      height_q <= DIM_W'(256);
      thr_q    <= THR_W'(320);
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_WIDTH:     width_q  <= pwdata[DIM_W-1:0];
        REG_HEIGHT:    height_q <= pwdata[DIM_W-1:0];
        REG_THRESHOLD: thr_q    <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:     prdata = 32'(width_q);
      REG_HEIGHT:    prdata = 32'(height_q);
      REG_THRESHOLD: prdata = 32'(thr_q);
      default:       prdata = '0;
    endcase
  end

  // Sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      proc_q  <= 1'b0;
      bg_q    <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we && (paddr[3:2] == REG_WIDTH || paddr[3:2] == REG_HEIGHT)) begin
        proc_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (operation_i)
              OP_LOAD:    proc_q  <= 1'b0;
              OP_PROCESS: state_q <= S_SETUP;
              OP_READ:    state_q <= S_RD;
              default: ;
            endcase
          end
        end
        S_RD:    state_q <= S_RESP;
        S_RESP: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_SETUP: state_q <= (sr_c == '0) ? S_BGFIN : S_CADDR;
        S_CADDR: state_q <= S_CACC;
        S_CACC: begin
          if (cc_q == sr_q - 1'b1 && cr_q == sr_q - 1'b1) begin
            state_q <= S_DIVST;
          end else begin
            state_q <= S_CADDR;
          end
        end
        S_DIVST: state_q <= S_DIVWT;
        S_DIVWT: begin
          if (div_done) begin
            if (ch_q != 2'd2) begin
              state_q <= S_DIVST;
            end else if (corner_q == 2'd3) begin
              state_q <= S_BGFIN;
            end else begin
              state_q <= S_CADDR;
            end
          end
        end
        S_BGFIN: begin
          for (int i = 0; i < 3; i++) begin
            bg_q[i] <= BG_W'((bgacc_q[i] + ACC_W'(2)) >> 2);
          end
          state_q <= S_TADDR;
        end
        S_TADDR: state_q <= S_TDATA;
        S_TDATA: state_q <= S_TMUL;
        S_TMUL:  state_q <= S_TADD;
        S_TADD:  state_q <= (ch_q == 2'd2) ? S_TCMP : S_TMUL;
        S_TCMP:  state_q <= (last_col && last_row) ? S_MRD : S_TADDR;
        S_MRD: begin
          if (dr_q == 3'd4 && dc_q == 3'd4) begin
            state_q <= S_MFIN;
          end
        end
        S_MFIN: begin
          if (last_col && last_row && pass_q == 2'd3) begin
            proc_q  <= 1'b1;
            state_q <= S_RESP;
          end else begin
            state_q <= S_MRD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        rd_ok_q <= proc_q && (DIM_W'(pixel_row_i) < eff_h) &&
                   (DIM_W'(pixel_col_i) < eff_w);
      end
      S_RD: hit_q <= rd_ok_q && a_rd_q;
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_mask_q <= hit_q;
          out_flag_q <= proc_q;
          out_bg_q   <= bg_q;
        end
      end
      S_SETUP: begin
        sr_q     <= sr_c;
        n_q      <= sr_ext * sr_ext;
        limit_q  <= {thr_sq, 8'b0};
        corner_q <= '0;
        cr_q     <= '0;
        cc_q     <= '0;
        ch_q     <= '0;
        sum_q    <= '{default: '0};
        bgacc_q  <= '{default: '0};
        hit_q    <= 1'b0;
      end
      S_CACC: begin
        for (int i = 0; i < 3; i++) begin
          sum_q[i] <= sum_q[i] + SUM_W'(chan_of(frame_rd_q, 2'(i)));
        end
        if (cc_q == sr_q - 1'b1) begin
          cc_q <= '0;
          cr_q <= (cr_q == sr_q - 1'b1) ? '0 : cr_q + 1'b1;
        end else begin
          cc_q <= cc_q + 1'b1;
        end
        ch_q <= '0;
      end
      S_DIVWT: begin
        if (div_done) begin
          bgacc_q[ch_q] <= bgacc_q[ch_q] + ACC_W'(div_q[BG_W-1:0]);
          if (ch_q == 2'd2) begin
            ch_q     <= '0;
            sum_q    <= '{default: '0};
            corner_q <= corner_q + 1'b1;
          end else begin
            ch_q <= ch_q + 1'b1;
          end
        end
      end
      S_BGFIN: begin
        r_q <= '0;
        c_q <= '0;
      end
      S_TDATA: begin
        pix_q  <= frame_rd_q;
        ch_q   <= '0;
        dacc_q <= '0;
      end
      S_TMUL: prod_q <= prod_c;
      S_TADD: begin
        dacc_q <= dacc_q + prod_q;
        ch_q   <= ch_q + 1'b1;
      end
      S_TCMP: begin
        // Advance the pixel; arm the first morphology pass after the last one
        if (last_col) begin
          c_q <= '0;
          r_q <= last_row ? '0 : r_q + 1'b1;
        end else begin
          c_q <= c_q + 1'b1;
        end
        pass_q <= '0;
        dr_q   <= '0;
        dc_q   <= '0;
        pend_q <= 1'b0;
        acc_q  <= 1'b0;
      end
      S_MRD: begin
        pend_q <= issue;
        acc_q  <= acc_next;
        if (dc_q == 3'd4) begin
          dc_q <= '0;
          dr_q <= (dr_q == 3'd4) ? '0 : dr_q + 1'b1;
        end else begin
          dc_q <= dc_q + 1'b1;
        end
      end
      S_MFIN: begin
        pend_q <= 1'b0;
        if (last_col) begin
          c_q <= '0;
          r_q <= last_row ? '0 : r_q + 1'b1;
        end else begin
          c_q <= c_q + 1'b1;
        end
        if (last_col && last_row) begin
          pass_q <= pass_q + 1'b1;
          // Next pass dilates only when it is the final one
          acc_q  <= (pass_q == 2'd2) ? 1'b0 : 1'b1;
        end else begin
          acc_q  <= dilate ? 1'b0 : 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign mask_value_o   = out_mask_q ? 8'd255 : 8'd0;
  assign mask_valid_o   = out_flag_q;
  assign background_l_o = out_bg_q[0];
  assign background_a_o = out_bg_q[1];
  assign background_b_o = out_bg_q[2];

  `CCBM_ASSERT_NEXT(a_proc_busy, accept && operation_i == OP_PROCESS,
                    state_q == S_SETUP, "process beat did not start the sequencer")
  `CCBM_ASSERT_IMPL(a_fg_flag, out_valid_o && mask_value_o != 8'd0,
                    mask_valid_o && mask_value_o == 8'd255, "foreground before processing")
  `CCBM_ASSERT_IMPL(a_no_load_busy, state_q != S_IDLE, !frame_we,
                    "frame written while processing")
  `CCBM_ASSERT_NEXT(a_dim_clears, cfg_we && paddr[3:2] == REG_WIDTH, !proc_q,
                    "width write left mask marked valid")

endmodule

>>> test/corner_color_background_mask_tb.sv
// Self-checking bench for corner_color_background_mask: load, process and read beats
// against a built-in model of the corner-mean background and the ellipse morphology.
// Depends on ccbm_pkg and the RTL of the block.
`timescale 1ns / 1ps
module corner_color_background_mask_tb
  import ccbm_pkg::*;
();

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned ITEM_GOAL = 1500;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] l;
    logic [7:0] a;
    logic [7:0] b;
  } pixel_beat_t;

  typedef struct packed {
    logic [7:0]  mask_value;
    logic        mask_valid;
    logic [15:0] bg_l;
    logic [15:0] bg_a;
    logic [15:0] bg_b;
  } mask_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] operation_i = '0;
  logic [7:0] pixel_row_i = '0;
  logic [7:0] pixel_col_i = '0;
  logic [7:0] lab_l_i = '0;
  logic [7:0] lab_a_i = '0;
  logic [7:0] lab_b_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] mask_value_o;
  logic mask_valid_o;
  logic [15:0] background_l_o;
  logic [15:0] background_a_o;
  logic [15:0] background_b_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  corner_color_background_mask dut (.*);

  always #5 clk_i = ~clk_i;

  // model state
  logic [23:0] frame_px [65536];
  bit fg_mask [65536];
  bit tmp_mask [65536];
  logic [15:0] bg_est [3];
  bit mask_ready;
  logic [8:0] cfg_width = 9'd256;
  logic [8:0] cfg_height = 9'd256;
  logic [11:0] cfg_thr = 12'd320;

  pixel_beat_t pending_beats [$];
  mask_result_t expected_results [$];
  int unsigned gap_max, stall_max;
  int unsigned tx_count, rx_count, cycles, errors;
  int unsigned n_items, n_loads, n_process, n_reads, n_phases;

  function automatic int eff_dim(input logic [8:0] v);
    if (v == 0) return 1;
    return (v > 256) ? 256 : int'(v);
  endfunction

  function automatic int unsigned chan(input logic [23:0] px, input int ch);
    return (px >> (16 - 8 * ch)) & 8'hFF;
  endfunction

  function automatic int unsigned corner_mean(input int r0, input int c0, input int sr,
                                              input int ch);
    int unsigned n, sum;
    n = sr * sr;
    sum = 0;
    if (n == 0) return 0;
    for (int r = r0; r < r0 + sr; r++)
      for (int c = c0; c < c0 + sr; c++)
        sum += chan(frame_px[r * 256 + c], ch);
    return (sum * 256 + n / 2) / n;
  endfunction

  // One ellipse pass; to_tmp picks fg_mask -> tmp_mask, else tmp_mask -> fg_mask.
  function automatic void morph_pass(input int h, input int w, input bit dilate,
                                     input bit to_tmp);
    bit acc, v;
    int rr, cc;
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        acc = !dilate;
        for (int dr = -2; dr <= 2; dr++)
          for (int dc = -2; dc <= 2; dc++) begin
            rr = r + dr;
            cc = c + dc;
            if (rr < 0 || rr >= h || cc < 0 || cc >= w) continue;
            // top and bottom rows of the ellipse hold only the center column
            if ((dr == -2 || dr == 2) && dc != 0) continue;
            v = to_tmp ? fg_mask[rr * 256 + cc] : tmp_mask[rr * 256 + cc];
            if (dilate) acc |= v; else acc &= v;
          end
        if (to_tmp) tmp_mask[r * 256 + c] = acc;
        else fg_mask[r * 256 + c] = acc;
      end
  endfunction

  function automatic void build_mask();
    int h, w, m, sr, idx;
    int unsigned s;
    longint unsigned limit, d2;
    longint d;
    h = eff_dim(cfg_height);
    w = eff_dim(cfg_width);
    m = ((h < w) ? h : w) / 4;
    sr = (m < 5) ? m : 5;
    for (int ch = 0; ch < 3; ch++) begin
      s = corner_mean(0, 0, sr, ch) + corner_mean(0, w - sr, sr, ch)
        + corner_mean(h - sr, 0, sr, ch) + corner_mean(h - sr, w - sr, sr, ch);
      bg_est[ch] = 16'((s + 2) >> 2);
    end
    limit = (longint'(cfg_thr) * longint'(cfg_thr)) << 8;
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        idx = r * 256 + c;
        d2 = 0;
        for (int ch = 0; ch < 3; ch++) begin
          d = longint'(chan(frame_px[idx], ch) << 8) - longint'(bg_est[ch]);
          d2 += d * d;
        end
        fg_mask[idx] = d2 > limit;
      end
    morph_pass(h, w, 1'b1, 1'b1);
    morph_pass(h, w, 1'b0, 1'b0);
    morph_pass(h, w, 1'b0, 1'b1);
    morph_pass(h, w, 1'b1, 1'b0);
    mask_ready = 1'b1;
  endfunction

  function automatic void take_beat(input pixel_beat_t bt);
    mask_result_t res;
    res = '0;
    case (bt.op)
      OP_LOAD: begin
        frame_px[{bt.row, bt.col}] = {bt.l, bt.a, bt.b};
        mask_ready = 1'b0;
        n_loads++;
      end
      OP_PROCESS: begin
        build_mask();
        n_process++;
      end
      OP_READ: begin
        if (mask_ready && bt.row < eff_dim(cfg_height) && bt.col < eff_dim(cfg_width)
            && fg_mask[{bt.row, bt.col}])
          res.mask_value = 8'd255;
        n_reads++;
      end
      default: ;
    endcase
    if (bt.op == OP_PROCESS || bt.op == OP_READ) begin
      res.mask_valid = mask_ready;
      res.bg_l = bg_est[0];
      res.bg_a = bg_est[1];
      res.bg_b = bg_est[2];
      expected_results = {expected_results, res};
    end
  endfunction

  // Monitor: model update on input beats, compare on output beats, watchdog.
  always @(posedge clk_i) begin
    mask_result_t want;
    if (rst_ni) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("corner_color_background_mask_tb failed");
        $finish;
      end else begin
        if (in_valid_i && !in_stall_o) begin
          take_beat({operation_i, pixel_row_i, pixel_col_i, lab_l_i, lab_a_i, lab_b_i});
          tx_count++;
        end
        if (out_valid_o && !out_stall_i) begin
          rx_count++;
          if (expected_results.size() == 0) begin
            $error("result beat with nothing expected");
            errors++;
          end else begin
            want = expected_results.pop_front();
            if (mask_value_o !== want.mask_value) begin
              $error("mask_value: expected %0d, got %0d", want.mask_value, mask_value_o);
              errors++;
            end
            if (mask_valid_o !== want.mask_valid) begin
              $error("mask_valid: expected %0d, got %0d", want.mask_valid, mask_valid_o);
              errors++;
            end
            if (background_l_o !== want.bg_l) begin
              $error("background_l: expected %0h, got %0h", want.bg_l, background_l_o);
              errors++;
            end
            if (background_a_o !== want.bg_a) begin
              $error("background_a: expected %0h, got %0h", want.bg_a, background_a_o);
              errors++;
            end
            if (background_b_o !== want.bg_b) begin
              $error("background_b: expected %0h, got %0h", want.bg_b, background_b_o);
              errors++;
            end
          end
        end
      end
    end
  end

  // Driver: present queued beats, hold while stalled, random gap after each beat.
  int unsigned tx_seen, gap_left;
  always @(negedge clk_i) begin
    pixel_beat_t bt;
    if (rst_ni && !(in_valid_i && tx_count == tx_seen)) begin
      if (tx_count != tx_seen) begin
        tx_seen = tx_count;
        gap_left = $urandom_range(0, gap_max);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        bt = pending_beats.pop_front();
        {operation_i, pixel_row_i, pixel_col_i, lab_l_i, lab_a_i, lab_b_i} <= bt;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side stall: random hold-off after each result beat.
  int unsigned rx_seen, stall_left;
  always @(negedge clk_i) begin
    if (rx_count != rx_seen) begin
      rx_seen = rx_count;
      stall_left = $urandom_range(0, stall_max);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic void push_beat(input logic [1:0] op, input int row, input int col,
                                    input int l, input int a, input int b);
    pixel_beat_t bt;
    bt = {op, row[7:0], col[7:0], l[7:0], a[7:0], b[7:0]};
    pending_beats = {pending_beats, bt};
    if (op != OP_UNUSED) n_items++;
  endfunction

  function automatic int near(input int base, input int spread);
    int v;
    v = base + $urandom_range(0, 2 * spread) - spread;
    return (v < 0) ? 0 : (v > 255) ? 255 : v;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WIDTH: begin cfg_width = val[8:0]; mask_ready = 1'b0; end
      REG_HEIGHT: begin cfg_height = val[8:0]; mask_ready = 1'b0; end
      REG_THRESHOLD: cfg_thr = val[11:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    do @(negedge clk_i);
    while (pending_beats.size() > 0 || in_valid_i || expected_results.size() > 0);
    repeat (10) @(negedge clk_i);
  endtask

  // Fill the image in use, process, then read it back with some noise mixed in.
  task automatic image_phase(input int reads);
    int h, w, base_l, base_a, base_b, spread;
    h = eff_dim(cfg_height);
    w = eff_dim(cfg_width);
    base_l = $urandom_range(0, 255);
    base_a = $urandom_range(0, 255);
    base_b = $urandom_range(0, 255);
    spread = $urandom_range(0, 20);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        if ($urandom_range(0, 9) < 7)
          push_beat(OP_LOAD, r, c, near(base_l, spread), near(base_a, spread),
                    near(base_b, spread));
        else
          push_beat(OP_LOAD, r, c, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255));
    // stray loads anywhere in the store
    repeat ($urandom_range(0, 4))
      push_beat(OP_LOAD, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) push_beat(OP_READ, 0, 0, 0, 0, 0);
    push_beat(OP_PROCESS, $urandom_range(0, 255), $urandom_range(0, 255), 0, 0, 0);
    repeat (reads) begin
      if ($urandom_range(0, 3) != 0)
        push_beat(OP_READ, $urandom_range(0, h - 1), $urandom_range(0, w - 1),
                  $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      else
        push_beat(OP_READ, $urandom_range(0, 255), $urandom_range(0, 255), 0, 0, 0);
      if ($urandom_range(0, 29) == 0) push_beat(OP_UNUSED, 0, 0, 0, 0, 0);
    end
    // a load drops the finished flag; reads after it return zero
    if ($urandom_range(0, 4) == 0) begin
      push_beat(OP_LOAD, $urandom_range(0, h - 1), $urandom_range(0, w - 1),
                $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      push_beat(OP_READ, $urandom_range(0, h - 1), $urandom_range(0, w - 1), 0, 0, 0);
    end
  endtask

  initial begin
    int sel, thr;
    gap_max = 0;
    stall_max = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: tiny 2x3 image gives an empty sample square
    write_reg(REG_WIDTH, 32'd3);
    write_reg(REG_HEIGHT, 32'd2);
    write_reg(REG_THRESHOLD, 32'd0);
    push_beat(OP_READ, 0, 0, 0, 0, 0);
    push_beat(OP_LOAD, 0, 0, 0, 0, 0);
    push_beat(OP_LOAD, 0, 1, 255, 255, 255);
    push_beat(OP_LOAD, 0, 2, 255, 0, 255);
    push_beat(OP_LOAD, 1, 0, 0, 255, 0);
    push_beat(OP_LOAD, 1, 1, 128, 128, 128);
    push_beat(OP_LOAD, 1, 2, 1, 2, 3);
    push_beat(OP_UNUSED, 1, 1, 0, 0, 0);
    push_beat(OP_PROCESS, 0, 0, 0, 0, 0);
    push_beat(OP_READ, 0, 0, 0, 0, 0);
    push_beat(OP_READ, 1, 2, 0, 0, 0);
    push_beat(OP_READ, 2, 0, 0, 0, 0);
    push_beat(OP_READ, 0, 3, 0, 0, 0);
    push_beat(OP_READ, 255, 255, 0, 0, 0);
    push_beat(OP_LOAD, 255, 255, 255, 255, 255);
    push_beat(OP_READ, 1, 1, 0, 0, 0);
    settle();
    write_reg(REG_THRESHOLD, 32'd4095);
    push_beat(OP_PROCESS, 0, 0, 0, 0, 0);
    push_beat(OP_READ, 0, 1, 0, 0, 0);
    settle();

    while (n_items < ITEM_GOAL) begin
      n_phases++;
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      stall_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
      sel = $urandom_range(0, 11);
      if (sel == 0) begin
        // one full-width row; register values above the maximum clamp
        write_reg(REG_WIDTH, $urandom_range(0, 1) ? 32'd256 : $urandom_range(257, 511));
        write_reg(REG_HEIGHT, $urandom_range(0, 1));
      end else if (sel == 1) begin
        write_reg(REG_WIDTH, $urandom_range(0, 1));
        write_reg(REG_HEIGHT, $urandom_range(0, 1) ? 32'd256 : $urandom_range(257, 511));
      end else begin
        write_reg(REG_WIDTH, $urandom_range(0, 12));
        write_reg(REG_HEIGHT, $urandom_range(0, 12));
      end
      sel = $urandom_range(0, 9);
      thr = (sel == 0) ? 0 : (sel == 1) ? 4095 : (sel == 2) ? $urandom_range(0, 4095)
          : $urandom_range(0, 900);
      write_reg(REG_THRESHOLD, thr);
      image_phase($urandom_range(20, 60));
      settle();
    end

    $display("covered %0d phases: %0d loads, %0d process runs, %0d mask reads",
             n_phases, n_loads, n_process, n_reads);
    if (errors == 0) $display("corner_color_background_mask_tb passed");
    else $display("corner_color_background_mask_tb failed");
    $finish;
  end

endmodule
